// ===== src/sms_pkg.sv =====
// Shared types, codes and constants of the SPI master shift engine.
package sms_pkg;

   localparam int MAX_WORD_BITS = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int WORD_LIMIT    = (MAX_WORD_BITS < 32) ? MAX_WORD_BITS : 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_BITS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_POL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_PHA   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_DRAIN  = 3'd5;

   localparam logic [15:0] RESET_HALF_PERIOD = 16'd500;
   localparam logic [5:0]  RESET_WORD_BITS   = 6'd8;

   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_SELECT   = 4'd1;
   localparam logic [3:0] OP_DESELECT = 4'd2;
   localparam logic [3:0] OP_TRANSFER = 4'd3;
   localparam logic [3:0] OP_READ     = 4'd4;
   localparam logic [3:0] OP_CLK_HI   = 4'd5;
   localparam logic [3:0] OP_CLK_LO   = 4'd6;
   localparam logic [3:0] OP_MOSI_HI  = 4'd7;
   localparam logic [3:0] OP_MOSI_LO  = 4'd8;
   localparam logic [3:0] OP_SAMPLE   = 4'd9;
   localparam logic [3:0] OP_PULSE    = 4'd10;
   localparam logic [3:0] OP_BITREAD  = 4'd11;

   typedef enum logic [3:0] {
      CMD_NOP      = 4'd0,
      CMD_SELECT   = 4'd1,
      CMD_DESELECT = 4'd2,
      CMD_XFER     = 4'd3,
      CMD_CLK_HI   = 4'd4,
      CMD_CLK_LO   = 4'd5,
      CMD_MOSI_HI  = 4'd6,
      CMD_MOSI_LO  = 4'd7,
      CMD_SAMPLE   = 4'd8,
      CMD_PULSE    = 4'd9,
      CMD_BITREAD  = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic [5:0]  word_bits;
      logic        clock_polarity;
      logic        clock_phase;
      logic        select_active_low;
      logic        open_drain;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] tx_word;
      logic [5:0]  bits;
      logic        miso;
   } item_type;

endpackage

// ===== src/sms_front.sv =====
// Front end: accept request words and classify them into queue items.
module sms_front (
   input  sms_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sms_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [3:0]                         req_tuser,
   input  logic                               queue_full,
   output logic                               push,
   output sms_pkg::item_type                  item
);
   import sms_pkg::*;

   logic [5:0]  eff_bits;
   logic [31:0] tx_mask;
   logic [31:0] tx_data;

   assign tx_data    = req_tdata[31:0];
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      if (cfg.word_bits == 6'd0) begin
         eff_bits = 6'd1;
      end else if (cfg.word_bits > 6'(WORD_LIMIT)) begin
         eff_bits = 6'(WORD_LIMIT);
      end else begin
         eff_bits = cfg.word_bits;
      end
   end

   assign tx_mask = 32'hFFFF_FFFF >> (6'd32 - eff_bits);

   always_comb begin
      item.miso    = req_tdata[32];
      item.tx_word = 32'd0;
      item.bits    = eff_bits;
      case (req_tuser)
         OP_SELECT:   item.cmd = CMD_SELECT;
         OP_DESELECT: item.cmd = CMD_DESELECT;
         OP_TRANSFER: begin
            item.cmd     = CMD_XFER;
            item.tx_word = tx_data & tx_mask;
         end
         OP_READ: begin
            item.cmd     = CMD_XFER;
            item.tx_word = 32'hFFFF_FFFF;
         end
         OP_CLK_HI:   item.cmd = CMD_CLK_HI;
         OP_CLK_LO:   item.cmd = CMD_CLK_LO;
         OP_MOSI_HI:  item.cmd = CMD_MOSI_HI;
         OP_MOSI_LO:  item.cmd = CMD_MOSI_LO;
         OP_SAMPLE:   item.cmd = CMD_SAMPLE;
         OP_PULSE:    item.cmd = CMD_PULSE;
         OP_BITREAD: begin
            item.cmd     = CMD_BITREAD;
            item.tx_word = 32'd1;
            item.bits    = 6'd1;
         end
         default:     item.cmd = CMD_NOP;
      endcase
   end

endmodule

// ===== src/sms_queue.sv =====
// Short queue of classified items between the front end and the engine.
module sms_queue #(
   parameter int DEPTH = sms_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sms_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output sms_pkg::item_type pop_item
);
   import sms_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
`endif

endmodule

// ===== src/sms_core.sv =====
// Back end: SPI pin engine stepping one tick per item, with output register.
module sms_core (
   input  logic                           clock,
   input  logic                           reset,
   input  sms_pkg::cfg_type               cfg,
   input  logic                           item_valid,
   input  sms_pkg::item_type              item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sms_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sms_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_XFER  = 3'b010,
      ST_PULSE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic        sclk_ff, sclk_in;
   logic        mosi_ff, mosi_in;
   logic        select_ff, select_in;
   logic        half_phase_ff, half_phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [5:0]  bits_left_ff, bits_left_in;
   logic [31:0] tx_ff, tx_in;
   logic [31:0] rx_ff, rx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0] hp;
   logic        expire;
   logic [5:0]  bits_dec;
   logic        start_sclk;
   logic [31:0] rx_out;
   logic        rx_valid;

   assign pop        = item_valid && (!rsp_valid_ff || rsp_tready);
   assign hp         = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
   assign expire     = ({1'b0, tick_ff} + 17'd1) >= {1'b0, hp};
   assign bits_dec   = bits_left_ff - 6'd1;
   assign start_sclk = (item.cmd == CMD_BITREAD) ? sclk_ff : cfg.clock_polarity;

   always_comb begin
      state_in      = state_ff;
      sclk_in       = sclk_ff;
      mosi_in       = mosi_ff;
      select_in     = select_ff;
      half_phase_in = half_phase_ff;
      tick_in       = tick_ff;
      bits_left_in  = bits_left_ff;
      tx_in         = tx_ff;
      rx_in         = rx_ff;
      rx_out        = 32'd0;
      rx_valid      = 1'b0;
      if (pop) begin
         case (state_ff)
            ST_IDLE: begin
               case (item.cmd)
                  CMD_SELECT:   select_in = !cfg.select_active_low;
                  CMD_DESELECT: select_in = cfg.select_active_low;
                  CMD_XFER, CMD_BITREAD: begin
                     sclk_in       = start_sclk ^ cfg.clock_phase;
                     tx_in         = item.tx_word;
                     bits_left_in  = item.bits;
                     mosi_in       = item.tx_word[5'(item.bits - 6'd1)];
                     rx_in         = 32'd0;
                     half_phase_in = 1'b0;
                     tick_in       = 16'd0;
                     state_in      = ST_XFER;
                  end
                  CMD_CLK_HI:   sclk_in = 1'b1;
                  CMD_CLK_LO:   sclk_in = 1'b0;
                  CMD_MOSI_HI:  mosi_in = 1'b1;
                  CMD_MOSI_LO:  mosi_in = 1'b0;
                  CMD_SAMPLE: begin
                     rx_out   = {31'd0, item.miso};
                     rx_valid = 1'b1;
                  end
                  CMD_PULSE: begin
                     sclk_in       = !cfg.clock_polarity;
                     half_phase_in = 1'b0;
                     tick_in       = 16'd0;
                     state_in      = ST_PULSE;
                  end
                  default: ;
               endcase
            end
            ST_XFER, ST_PULSE: begin
               if (!expire) begin
                  tick_in = tick_ff + 16'd1;
               end else begin
                  tick_in = 16'd0;
                  half_phase_in = !half_phase_ff;
                  if (!half_phase_ff) begin
                     if (state_ff == ST_PULSE) begin
                        sclk_in = cfg.clock_polarity;
                     end else begin
                        sclk_in = !sclk_ff;
                        rx_in   = {rx_ff[30:0], item.miso};
                     end
                  end else if (state_ff == ST_PULSE) begin
                     state_in = ST_IDLE;
                  end else begin
                     bits_left_in = bits_dec;
                     if (bits_dec == 6'd0) begin
                        sclk_in  = sclk_ff ^ !cfg.clock_phase;
                        rx_out   = rx_ff;
                        rx_valid = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        sclk_in = !sclk_ff;
                        mosi_in = tx_ff[5'(bits_dec - 6'd1)];
                     end
                  end
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rx_valid, rx_out, (state_in != ST_IDLE),
                         !(cfg.open_drain && select_in),
                         !(cfg.open_drain && mosi_in),
                         !(cfg.open_drain && sclk_in),
                         select_in, mosi_in, sclk_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sclk_ff       <= 1'b0;
         mosi_ff       <= 1'b0;
         select_ff     <= 1'b1;
         half_phase_ff <= 1'b0;
         tick_ff       <= 16'd0;
         bits_left_ff  <= 6'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sclk_ff       <= sclk_in;
         mosi_ff       <= mosi_in;
         select_ff     <= select_in;
         half_phase_ff <= half_phase_in;
         tick_ff       <= tick_in;
         bits_left_ff  <= bits_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= 32'd0;
         rx_ff <= 32'd0;
      end else begin
         tx_ff <= tx_in;
         rx_ff <= rx_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_xfer_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XFER) |-> (bits_left_ff != 6'd0))
      else $error("transfer running with no bits left");
   a_rx_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[RSP_DATA_W-1]) |-> !rsp_data_ff[6])
      else $error("receive completed while still busy");
   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[RSP_DATA_W-1]) |-> (rsp_data_ff[38:7] == 32'd0))
      else $error("receive data without receive flag");
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      (pop && state_ff == ST_IDLE && item.cmd == CMD_PULSE) |=> state_ff == ST_PULSE)
      else $error("pulse did not start");
`endif

endmodule

// ===== src/spi_master_shift_engine_top.sv =====
// Path: a request word is written into the queue, then popped into the engine,
// whose output register holds its response word until the response is taken.
// Throughput: one word per cycle while responses are taken; the engine steps one tick per word. A full
// queue holds off requests until the engine has popped one word.
// Reset: synchronous, active high; clears control state and loads register
// defaults; no clearing pass, requests are taken right after reset.
module spi_master_shift_engine_top #(
   parameter int QUEUE_DEPTH = sms_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] tx_data, [32] miso_level, [39:33] zero
   input  logic [sms_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [3:0] operation
   input  logic [3:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] sclk_level, [1] mosi_level, [2] select_level, [3] sclk_drive,
   // [4] mosi_drive, [5] select_drive, [6] busy_res, [38:7] rx_data, [39] rx_valid
   output logic [sms_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sms_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sms_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type push_item, pop_item;
   logic     push, pop, queue_full, queue_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD: cfg_in.half_period       = csr_data;
            CSR_WORD_BITS:   cfg_in.word_bits         = csr_data[5:0];
            CSR_CLOCK_POL:   cfg_in.clock_polarity    = csr_data[0];
            CSR_CLOCK_PHA:   cfg_in.clock_phase       = csr_data[0];
            CSR_SELECT_LOW:  cfg_in.select_active_low = csr_data[0];
            CSR_OPEN_DRAIN:  cfg_in.open_drain        = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period       <= RESET_HALF_PERIOD;
         cfg_ff.word_bits         <= RESET_WORD_BITS;
         cfg_ff.clock_polarity    <= 1'b1;
         cfg_ff.clock_phase       <= 1'b1;
         cfg_ff.select_active_low <= 1'b1;
         cfg_ff.open_drain        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sms_front u_front (
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   sms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .valid     (queue_valid),
      .pop_item  (pop_item)
   );

   sms_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (queue_valid),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_spi_master_shift_engine_top.sv =====
// Self-checking testbench: streams SPI tick commands and checks each response word.
module tb_spi_master_shift_engine_top;
   import sms_pkg::*;

   localparam logic [3:0] OP_RESERVED_FIRST = 4'd12;
   localparam logic [3:0] OP_RESERVED_LAST  = 4'd15;
   localparam int PLAN_LEN  = 28;
   localparam int HOLD_OFF  = 300;
   localparam int COMMANDS  = 750;
   localparam int CALM_LEN  = 60;

   typedef struct packed {
      logic        is_reg;
      logic [2:0]  index;
      logic [3:0]  op;
      logic [31:0] data;
      logic        miso;
      logic        check;
      logic [39:0] want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [3:0] req_tuser = OP_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HALF_PERIOD;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type shadow_cfg = '{half_period: RESET_HALF_PERIOD, word_bits: RESET_WORD_BITS,
                           clock_polarity: 1'b1, clock_phase: 1'b1,
                           select_active_low: 1'b1, open_drain: 1'b0};
   logic        pin_sclk   = 1'b0;
   logic        pin_mosi   = 1'b0;
   logic        pin_select = 1'b1;
   logic [3:0]  eng_cmd    = OP_NOP;
   logic        eng_half   = 1'b0;
   logic [15:0] eng_ticks  = '0;
   logic [5:0]  eng_bits   = '0;
   logic [31:0] eng_tx     = '0;
   logic [31:0] eng_rx     = '0;

   logic [39:0] rsp_expected [$];
   int mismatches = 0;
   int hold_off_asks = 0;
   int hold_off_served = 0;
   int hold_left = 0;
   int sent = 0;
   logic calm = 1'b0;

   string field_name [9] = '{"sclk_level", "mosi_level", "select_level", "sclk_drive",
                             "mosi_drive", "select_drive", "busy_res", "rx_data", "rx_valid"};
   int field_lo [9] = '{0, 1, 2, 3, 4, 5, 6, 7, 39};
   int field_hi [9] = '{0, 1, 2, 3, 4, 5, 6, 38, 39};

   plan_row_type plan [PLAN_LEN] = '{
      '{1'b0, CSR_HALF_PERIOD, OP_NOP,            32'h0,        1'b0, 1'b1, 40'h00_0000_003C},
      '{1'b0, CSR_HALF_PERIOD, OP_SAMPLE,         32'h0,        1'b1, 1'b1, 40'h80_0000_00BC},
      '{1'b0, CSR_HALF_PERIOD, OP_SAMPLE,         32'hFFFFFFFF, 1'b0, 1'b1, 40'h80_0000_003C},
      '{1'b0, CSR_HALF_PERIOD, OP_RESERVED_LAST,  32'hFFFFFFFF, 1'b1, 1'b1, 40'h00_0000_003C},
      '{1'b0, CSR_HALF_PERIOD, OP_RESERVED_FIRST, 32'h0,        1'b0, 1'b1, 40'h00_0000_003C},
      '{1'b0, CSR_HALF_PERIOD, OP_SELECT,         32'h0,        1'b0, 1'b1, 40'h00_0000_0038},
      '{1'b0, CSR_HALF_PERIOD, OP_CLK_HI,         32'h0,        1'b0, 1'b1, 40'h00_0000_0039},
      '{1'b0, CSR_HALF_PERIOD, OP_MOSI_HI,        32'h0,        1'b0, 1'b1, 40'h00_0000_003B},
      '{1'b0, CSR_HALF_PERIOD, OP_CLK_LO,         32'h0,        1'b0, 1'b1, 40'h00_0000_003A},
      '{1'b0, CSR_HALF_PERIOD, OP_MOSI_LO,        32'h0,        1'b0, 1'b1, 40'h00_0000_0038},
      '{1'b0, CSR_HALF_PERIOD, OP_DESELECT,       32'h0,        1'b0, 1'b1, 40'h00_0000_003C},
      '{1'b1, CSR_HALF_PERIOD, OP_NOP,            32'h0001,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_TRANSFER,       32'hFFFFFFA5, 1'b1, 1'b0, '0},
      '{1'b1, CSR_WORD_BITS,   OP_NOP,            32'hFFE0,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_TRANSFER,       32'hFFFFFFFF, 1'b1, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_READ,           32'h0,        1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_PULSE,          32'h0,        1'b1, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_BITREAD,        32'h0,        1'b1, 1'b0, '0},
      '{1'b1, CSR_WORD_BITS,   OP_NOP,            32'h0000,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_TRANSFER,       32'h00000001, 1'b1, 1'b0, '0},
      '{1'b1, CSR_WORD_BITS,   OP_NOP,            32'hFFFF,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_TRANSFER,       32'h80000000, 1'b0, 1'b0, '0},
      '{1'b1, CSR_CLOCK_POL,   OP_NOP,            32'hFFFE,     1'b0, 1'b0, '0},
      '{1'b1, CSR_CLOCK_PHA,   OP_NOP,            32'h0000,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_TRANSFER,       32'h5A5A5A5A, 1'b1, 1'b0, '0},
      '{1'b1, CSR_HALF_PERIOD, OP_NOP,            32'h0000,     1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_PULSE,          32'h0,        1'b0, 1'b0, '0},
      '{1'b0, CSR_HALF_PERIOD, OP_BITREAD,        32'h0,        1'b0, 1'b0, '0}
   };

   spi_master_shift_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void start_bit();
      if (shadow_cfg.clock_phase) pin_sclk = ~pin_sclk;
      pin_mosi = eng_tx[5'(eng_bits - 6'd1)];
   endfunction

   function automatic logic [39:0] tick_engine(input logic [3:0] op, input logic [31:0] data,
                                               input logic miso);
      logic [31:0] rx_word;
      logic        rx_flag;
      logic [5:0]  n;
      logic [15:0] hp;
      rx_word = '0;
      rx_flag = 1'b0;
      if (eng_cmd == OP_NOP) begin
         case (op)
            OP_SELECT:   pin_select = ~shadow_cfg.select_active_low;
            OP_DESELECT: pin_select = shadow_cfg.select_active_low;
            OP_TRANSFER, OP_READ: begin
               n = shadow_cfg.word_bits;
               if (n == 6'd0) n = 6'd1;
               if (n > 6'(WORD_LIMIT)) n = 6'(WORD_LIMIT);
               pin_sclk = shadow_cfg.clock_polarity;
               if (op == OP_TRANSFER)
                  eng_tx = (n >= 6'd32) ? data : (data & ((32'h1 << n) - 32'h1));
               else
                  eng_tx = 32'hFFFFFFFF;
               eng_bits = n;
               eng_rx = '0;
               eng_half = 1'b0;
               eng_ticks = '0;
               eng_cmd = op;
               start_bit();
            end
            OP_CLK_HI:  pin_sclk = 1'b1;
            OP_CLK_LO:  pin_sclk = 1'b0;
            OP_MOSI_HI: pin_mosi = 1'b1;
            OP_MOSI_LO: pin_mosi = 1'b0;
            OP_SAMPLE: begin
               rx_word = {31'b0, miso};
               rx_flag = 1'b1;
            end
            OP_PULSE: begin
               pin_sclk = ~shadow_cfg.clock_polarity;
               eng_half = 1'b0;
               eng_ticks = '0;
               eng_cmd = OP_PULSE;
            end
            OP_BITREAD: begin
               eng_tx = 32'h1;
               eng_bits = 6'd1;
               eng_rx = '0;
               eng_half = 1'b0;
               eng_ticks = '0;
               eng_cmd = OP_BITREAD;
               start_bit();
            end
            default: ;
         endcase
      end else begin
         hp = (shadow_cfg.half_period == 16'd0) ? 16'd1 : shadow_cfg.half_period;
         if ({1'b0, eng_ticks} + 17'd1 >= {1'b0, hp}) begin
            eng_ticks = '0;
            if (!eng_half) begin
               eng_half = 1'b1;
               if (eng_cmd == OP_PULSE) begin
                  pin_sclk = shadow_cfg.clock_polarity;
               end else begin
                  pin_sclk = ~pin_sclk;
                  eng_rx = {eng_rx[30:0], miso};
               end
            end else begin
               eng_half = 1'b0;
               if (eng_cmd == OP_PULSE) begin
                  eng_cmd = OP_NOP;
               end else begin
                  if (!shadow_cfg.clock_phase) pin_sclk = ~pin_sclk;
                  eng_bits = eng_bits - 6'd1;
                  if (eng_bits == 6'd0) begin
                     rx_word = eng_rx;
                     rx_flag = 1'b1;
                     eng_cmd = OP_NOP;
                  end else begin
                     start_bit();
                  end
               end
            end
         end else begin
            eng_ticks = eng_ticks + 16'd1;
         end
      end
      return {rx_flag, rx_word, eng_cmd != OP_NOP,
              ~(shadow_cfg.open_drain & pin_select), ~(shadow_cfg.open_drain & pin_mosi),
              ~(shadow_cfg.open_drain & pin_sclk), pin_select, pin_mosi, pin_sclk};
   endfunction

   task automatic offer(input logic [3:0] op, input logic [31:0] data, input logic miso,
                        input logic check, input logic [39:0] want);
      logic [39:0] guess;
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'b0, miso, data};
      csr_valid <= 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      guess = tick_engine(op, data, miso);
      rsp_expected.push_back(check ? want : guess);
      sent++;
      @(negedge clock);
   endtask

   task automatic finish_command();
      while (eng_cmd != OP_NOP)
         offer(($urandom_range(99) < 30) ? 4'($urandom_range(15)) : OP_NOP,
               $urandom, 1'($urandom), 1'b0, '0);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      @(negedge clock);
      while (rsp_expected.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_HALF_PERIOD: shadow_cfg.half_period = value;
         CSR_WORD_BITS:   shadow_cfg.word_bits = value[5:0];
         CSR_CLOCK_POL:   shadow_cfg.clock_polarity = value[0];
         CSR_CLOCK_PHA:   shadow_cfg.clock_phase = value[0];
         CSR_SELECT_LOW:  shadow_cfg.select_active_low = value[0];
         CSR_OPEN_DRAIN:  shadow_cfg.open_drain = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [39:0] want,
                                input logic [39:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("rsp mismatch (%s): expected %h got %h at %0t", what, want, got, $time);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_off_served != hold_off_asks) begin
         hold_off_served = hold_off_asks;
         hold_left = HOLD_OFF;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 21);
      end
   end

   always @(posedge clock) begin
      logic [39:0] want;
      logic [63:0] diff;
      string bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expected.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_tdata);
         end else begin
            want = rsp_expected.pop_front();
            bad = "";
            for (int f = 0; f < 9; f++) begin
               diff = 64'(want ^ rsp_tdata) >> field_lo[f];
               diff = diff & ((64'h1 << (field_hi[f] - field_lo[f] + 1)) - 64'h1);
               if (diff != 0) bad = {bad, " ", field_name[f]};
            end
            if (bad != "") note_mismatch(bad, want, rsp_tdata);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int phase;
      int pick;
      logic [3:0] op;
      logic [15:0] hp;
      logic [5:0] bits;
      phase = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].is_reg) begin
            settle();
            write_reg(plan[i].index, plan[i].data[15:0]);
         end else begin
            offer(plan[i].op, plan[i].data, plan[i].miso, plan[i].check, plan[i].want);
            finish_command();
         end
      end

      // hold the slowest clock for a long stretch with no idling on either side
      settle();
      calm = 1'b1;
      write_reg(CSR_HALF_PERIOD, 16'hFFFF);
      offer(OP_PULSE, $urandom, 1'($urandom), 1'b0, '0);
      repeat (CALM_LEN) offer(4'($urandom_range(15)), $urandom, 1'($urandom), 1'b0, '0);
      settle();
      write_reg(CSR_HALF_PERIOD, 16'd1);
      finish_command();
      settle();
      calm = 1'b0;

      while (sent < COMMANDS) begin
         settle();
         pick = $urandom_range(99);
         if (pick < 60)      hp = 16'($urandom_range(2, 1));
         else if (pick < 80) hp = 16'd0;
         else                hp = 16'($urandom_range(4, 3));
         pick = $urandom_range(99);
         if (pick < 50)      bits = 6'($urandom_range(8, 1));
         else if (pick < 80) bits = 6'($urandom_range(32, 9));
         else if (pick < 90) bits = 6'd0;
         else                bits = 6'($urandom_range(63, 33));
         write_reg(CSR_HALF_PERIOD, hp);
         write_reg(CSR_WORD_BITS, {10'($urandom), bits});
         write_reg(CSR_CLOCK_POL, 16'($urandom));
         write_reg(CSR_CLOCK_PHA, 16'($urandom));
         write_reg(CSR_SELECT_LOW, 16'($urandom));
         write_reg(CSR_OPEN_DRAIN, 16'($urandom));
         if (phase % 3 == 0) hold_off_asks++;
         offer(OP_SELECT, $urandom, 1'($urandom), 1'b0, '0);
         repeat ($urandom_range(8, 3)) begin
            pick = $urandom_range(99);
            if (pick < 25)      op = OP_TRANSFER;
            else if (pick < 35) op = OP_READ;
            else if (pick < 45) op = OP_BITREAD;
            else if (pick < 55) op = OP_PULSE;
            else                op = 4'($urandom_range(15));
            offer(op, $urandom, 1'($urandom), 1'b0, '0);
            finish_command();
         end
         offer(OP_DESELECT, $urandom, 1'($urandom), 1'b0, '0);
         phase++;
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== spi_master_shift_engine_top.f =====
src/sms_pkg.sv
src/sms_front.sv
src/sms_queue.sv
src/sms_core.sv
src/spi_master_shift_engine_top.sv
tb/tb_spi_master_shift_engine_top.sv
